[rtl/annexb_nalu_splitter_macros.svh]
// Assertion macros for the Annex B start code parser.
`ifndef ANNEXB_NALU_SPLITTER_MACROS_SVH
`define ANNEXB_NALU_SPLITTER_MACROS_SVH

// Clocked check, off while reset is asserted.
`define ANNEXB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define ANNEXB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/annexb_pkg.sv]
// Types and constants for the Annex B start code parser.
`default_nettype none

package annexb_pkg;

    localparam int BYTE_BITS       = 8;
    localparam int OFF_FIELD_BITS  = 20;
    localparam int SIZE_FIELD_BITS = 21;
    localparam int TYPE_BITS       = 5;
    localparam int HIST_BITS       = 3 * BYTE_BITS;

    localparam logic [BYTE_BITS-1:0] START_CODE_BYTE = 8'h01;
    localparam logic [BYTE_BITS-1:0] ZERO_BYTE       = 8'h00;

    typedef struct packed {
        logic [BYTE_BITS-1:0] data_byte;
        logic                 last_byte;
    } byte_item_t;

    typedef struct packed {
        logic [OFF_FIELD_BITS-1:0]  unit_start;
        logic [OFF_FIELD_BITS-1:0]  unit_payload_offset;
        logic [SIZE_FIELD_BITS-1:0] unit_payload_size;
        logic [TYPE_BITS-1:0]       unit_type;
        logic                       final_unit;
    } unit_item_t;

endpackage

`default_nettype wire

[rtl/annexb_nalu_splitter.sv]
// Top level of the Annex B start code parser: byte scan and unit descriptors.
//
// channel  direction  handshake               payload
// byte     in         byte_valid, byte_stall  byte_item_t
// unit     out        unit_valid, unit_stall  unit_item_t
//
// One byte per cycle while unit is not stalled; each descriptor is registered.
// The scan state updates in one pass between the input register and the
// result register, so that single stage sets the rate.
// Reset is asynchronous and clears the scan state and both valid flags.
// A stall on unit holds the result register and backs up to byte_stall
// in the same cycle.
`default_nettype none

module annexb_nalu_splitter
    import annexb_pkg::*;
#(
    parameter int OFFSET_BITS = 20
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_valid,
    output logic            byte_stall,
    input  wire byte_item_t byte_data,
    output logic            unit_valid,
    input  wire logic       unit_stall,
    output unit_item_t      unit_data
);

    localparam int OBW     = OFFSET_BITS + 1;
    localparam int EXT_OFF = (OFFSET_BITS > OFF_FIELD_BITS) ? OFFSET_BITS : OFF_FIELD_BITS;
    localparam int EXT_SZ  = (OBW > SIZE_FIELD_BITS) ? OBW : SIZE_FIELD_BITS;
    localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

    logic                   item_valid_reg;
    logic                   item_valid_next;
    byte_item_t             item_reg;

    logic                   unit_valid_reg;
    logic                   unit_valid_next;
    unit_item_t             unit_reg;
    unit_item_t             unit_next;

    logic [HIST_BITS-1:0]   hist_reg;
    logic [HIST_BITS-1:0]   hist_next;
    logic [1:0]             cnt_reg;
    logic [1:0]             cnt_next;
    logic [OFFSET_BITS-1:0] pos_reg;
    logic [OFFSET_BITS-1:0] pos_next;
    logic                   open_reg;
    logic                   open_next;
    logic [OFFSET_BITS-1:0] open_start_reg;
    logic [OFFSET_BITS-1:0] open_start_next;
    logic [OFFSET_BITS-1:0] open_pay_reg;
    logic [OFFSET_BITS-1:0] open_pay_next;
    logic [TYPE_BITS-1:0]   open_type_reg;
    logic [TYPE_BITS-1:0]   open_type_next;
    logic                   awaiting_reg;
    logic                   awaiting_next;

    logic                   advance;
    logic                   accept;
    logic [BYTE_BITS-1:0]   b;
    logic                   last;
    logic [OFFSET_BITS-1:0] cur_inc;
    logic [OFFSET_BITS-1:0] cur_m2;
    logic [OFFSET_BITS-1:0] cur_m3;
    logic [OFFSET_BITS-1:0] sc_start;
    logic [OFFSET_BITS-1:0] mid_size;
    logic [OBW-1:0]         end_pos;
    logic [OBW-1:0]         open_pay_ext;
    logic [OBW-1:0]         end_size;
    logic [OBW-1:0]         size_sel;
    logic [TYPE_BITS-1:0]   type_eff;
    logic                   start_code;
    logic                   four_byte;
    logic                   emit;
    logic [EXT_OFF-1:0]     start_ext;
    logic [EXT_OFF-1:0]     pay_ext;
    logic [EXT_SZ-1:0]      size_ext;

    assign advance    = item_valid_reg && (!unit_valid_reg || !unit_stall);
    assign byte_stall = item_valid_reg && !advance;
    assign accept     = byte_valid && !byte_stall;

    assign b    = item_reg.data_byte;
    assign last = item_reg.last_byte;

    always_comb
    begin
        cur_inc  = (pos_reg == POS_MAX) ? pos_reg : pos_reg + OFFSET_BITS'(1);
        cur_m2   = (pos_reg > OFFSET_BITS'(2)) ? pos_reg - OFFSET_BITS'(2) : '0;
        cur_m3   = (pos_reg > OFFSET_BITS'(3)) ? pos_reg - OFFSET_BITS'(3) : '0;
        type_eff = awaiting_reg ? b[TYPE_BITS-1:0] : open_type_reg;

        start_code = !last && (b == START_CODE_BYTE) && (cnt_reg >= 2'd2)
                     && (hist_reg[2*BYTE_BITS-1:0] == {ZERO_BYTE, ZERO_BYTE});
        four_byte  = (cnt_reg == 2'd3)
                     && (hist_reg[HIST_BITS-1:2*BYTE_BITS] == ZERO_BYTE);
        sc_start   = four_byte ? cur_m3 : cur_m2;

        mid_size     = (sc_start > open_pay_reg) ? sc_start - open_pay_reg : '0;
        end_pos      = {1'b0, pos_reg} + OBW'(1);
        open_pay_ext = {1'b0, open_pay_reg};
        end_size     = (end_pos > open_pay_ext) ? end_pos - open_pay_ext : '0;
        size_sel     = last ? end_size : {1'b0, mid_size};

        emit = open_reg && (last || start_code);

        start_ext = EXT_OFF'(open_start_reg);
        pay_ext   = EXT_OFF'(open_pay_reg);
        size_ext  = EXT_SZ'(size_sel);

        unit_next.unit_start          = start_ext[OFF_FIELD_BITS-1:0];
        unit_next.unit_payload_offset = pay_ext[OFF_FIELD_BITS-1:0];
        unit_next.unit_payload_size   = size_ext[SIZE_FIELD_BITS-1:0];
        unit_next.unit_type           = (size_sel == '0) ? '0 : type_eff;
        unit_next.final_unit          = last;
    end

    always_comb
    begin
        hist_next       = hist_reg;
        cnt_next        = cnt_reg;
        pos_next        = pos_reg;
        open_next       = open_reg;
        open_start_next = open_start_reg;
        open_pay_next   = open_pay_reg;
        open_type_next  = open_type_reg;
        awaiting_next   = awaiting_reg;
        if (advance)
        begin
            if (last)
            begin
                hist_next       = '0;
                cnt_next        = '0;
                pos_next        = '0;
                open_next       = 1'b0;
                open_start_next = '0;
                open_pay_next   = '0;
                open_type_next  = '0;
                awaiting_next   = 1'b0;
            end
            else
            begin
                hist_next = {hist_reg[2*BYTE_BITS-1:0], b};
                cnt_next  = (cnt_reg == 2'd3) ? cnt_reg : cnt_reg + 2'd1;
                pos_next  = cur_inc;
                if (start_code)
                begin
                    open_next       = 1'b1;
                    open_start_next = sc_start;
                    open_pay_next   = cur_inc;
                    open_type_next  = '0;
                    awaiting_next   = 1'b1;
                end
                else if (awaiting_reg)
                begin
                    open_type_next = b[TYPE_BITS-1:0];
                    awaiting_next  = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        if (accept)
            item_valid_next = 1'b1;
        else if (advance)
            item_valid_next = 1'b0;
        else
            item_valid_next = item_valid_reg;

        if (advance)
            unit_valid_next = emit;
        else if (!unit_stall)
            unit_valid_next = 1'b0;
        else
            unit_valid_next = unit_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            unit_valid_reg <= 1'b0;
            hist_reg       <= '0;
            cnt_reg        <= '0;
            pos_reg        <= '0;
            open_reg       <= 1'b0;
            open_start_reg <= '0;
            open_pay_reg   <= '0;
            open_type_reg  <= '0;
            awaiting_reg   <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            unit_valid_reg <= unit_valid_next;
            hist_reg       <= hist_next;
            cnt_reg        <= cnt_next;
            pos_reg        <= pos_next;
            open_reg       <= open_next;
            open_start_reg <= open_start_next;
            open_pay_reg   <= open_pay_next;
            open_type_reg  <= open_type_next;
            awaiting_reg   <= awaiting_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= byte_data;
        if (advance && emit)
            unit_reg <= unit_next;
    end

    assign unit_valid = unit_valid_reg;
    assign unit_data  = unit_reg;

endmodule

`default_nettype wire

[rtl/annexb_chk.sv]
// Port checker for the Annex B start code parser and its bind.
`default_nettype none

`include "annexb_nalu_splitter_macros.svh"

module annexb_chk
    import annexb_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       byte_valid,
    input wire logic       byte_stall,
    input wire byte_item_t byte_data,
    input wire logic       unit_valid,
    input wire logic       unit_stall,
    input wire unit_item_t unit_data
);

    `ANNEXB_ASSERT(a_unit_hold, clk, rst_n, unit_valid && unit_stall |=> unit_valid, "unit transfer dropped while stalled")
    `ANNEXB_ASSERT(a_unit_stable, clk, rst_n, unit_valid && unit_stall |=> $stable(unit_data), "unit payload changed while stalled")
    `ANNEXB_ASSERT(a_offset_past_start, clk, rst_n, unit_valid |-> unit_data.unit_payload_offset != unit_data.unit_start, "payload offset equals start code offset")
    `ANNEXB_ASSERT(a_empty_type, clk, rst_n, unit_valid && unit_data.unit_payload_size == '0 |-> unit_data.unit_type == '0, "empty unit with nonzero type")
    `ANNEXB_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !unit_valid, "unit valid out of reset")

endmodule

bind annexb_nalu_splitter annexb_chk u_annexb_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data),
    .unit_valid (unit_valid),
    .unit_stall (unit_stall),
    .unit_data  (unit_data)
);

`default_nettype wire
